[hdl/rgd_pkg.sv]
// Package: widths, sigmoid table helper and saturation helpers for the gradient descent block.
`timescale 1ns / 1ps
package rgd_pkg;

  localparam int unsigned MaxBatchDefault = 1024;
  localparam int unsigned SigEntriesDefault = 256;
  localparam int unsigned LrReset = 655;

  localparam int unsigned RegLossMode = 0;
  localparam int unsigned RegLearnRate = 1;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic signed [7:0]  target_label;
    logic               batch_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] weight_now;
    logic signed [31:0] bias_now;
    logic signed [31:0] residual;
    logic               weights_updated;
  } out_item_t;

  // saturate a 64-bit value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd140737488355327;
    lo = -64'sd140737488355328;
    if (v > hi) return 48'sh7fffffffffff;
    else if (v < lo) return 48'sh800000000000;
    else return v[47:0];
  endfunction

  // e^-a in Q.32, a in Q.16; elaboration-time only
  function automatic longint unsigned exp_neg_q32(input longint unsigned a);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned u3;
    longint unsigned v;
    u = a << 8;
    u2 = (u * u) >> 32;
    u3 = (u2 * u) >> 32;
    v = 64'd4294967296 - u + u2 / 2 - u3 / 6;
    if (v > 64'd4294967295) v = 64'd4294967295;
    for (int i = 0; i < 8; i++) v = (v * v) >> 32;
    return v;
  endfunction

endpackage

[hdl/rgd_if.sv]
// Valid/ready channel interface.
`timescale 1ns / 1ps
interface rgd_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/rgd_divider.sv]
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module rgd_divider #(
  parameter int unsigned DenW = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [47:0]     num_i,
  input  logic [DenW-1:0]        den_i,
  output logic                   done_o,
  output logic signed [47:0]     quo_o
);
  localparam int unsigned CntW = 6;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            neg_q, neg_d;
  logic [47:0]     quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;
  logic [47:0]     quo_nx;
  logic [DenW:0]   rem_nx;

  // done depends only on state, so a new start may share the done cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    trial = {rem_q[DenW-1:0], quo_q[47]};
    quo_nx = {quo_q[46:0], 1'b0};
    rem_nx = trial;
    if (trial >= {1'b0, den_q}) begin
      rem_nx = trial - {1'b0, den_q};
      quo_nx[0] = 1'b1;
    end
    done_o = busy_q && (cnt_q == '0);
    if (busy_q) begin
      quo_d = quo_nx;
      rem_d = rem_nx;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) busy_d = 1'b0;
    end
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = CntW'(47);
      neg_d = num_i[47];
      quo_d = num_i[47] ? 48'(-num_i) : num_i;
      rem_d = '0;
      den_d = den_i;
    end
  end

  // magnitude fits in 48 bits unsigned; negate only on the signed case
  assign quo_o = neg_q ? 48'(-quo_nx) : quo_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q)
    else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o && !start_i |=> !busy_q)
    else $error("divider still busy after done");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q && !start_i |=>
                   cnt_q == $past(cnt_q) - CntW'(1) || !busy_q)
    else $error("divider count skipped");
endmodule

[hdl/regression_gradient_descent.sv]
// Top level: single-feature batch gradient descent with a shared multiplier and divider.
// Per sample: predict (multiply, then add bias), gradient multiply and accumulate, with the
//   multiply steps on one shared 49x17 multiplier; a batch-end sample adds two serial
//   divisions (weight, then bias) plus two multiplies for the weight and bias steps.
// Flow: one sample at a time; a new sample is taken only after the last result is
//   accepted, since in_ready is high only in the idle state.
// Reset (rst_ni low, async): weight, bias, sums and count clear, loss_mode 0,
//   learning_rate 655; no clearing pass.
`timescale 1ns / 1ps
module regression_gradient_descent #(
  parameter int unsigned MAX_BATCH = rgd_pkg::MaxBatchDefault,
  parameter int unsigned SIGMOID_ENTRIES = rgd_pkg::SigEntriesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rgd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rgd_pkg::CfgDataW-1:0] cfg_data_i,
  rgd_if.sink                          in_if,
  rgd_if.source                        out_if
);
  localparam int unsigned CntW = $clog2(MAX_BATCH + 1);
  localparam int unsigned SigIdxW = $clog2(SIGMOID_ENTRIES);
  localparam int unsigned BinShift = $clog2(1048576 / SIGMOID_ENTRIES);
  localparam longint BinW = longint'(1048576 / SIGMOID_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_PRED, S_PADD, S_GRAD, S_ACC, S_DIVW, S_DIVB, S_STEPW, S_STEPB, S_OUT
  } state_e;

  state_e state_q;
  logic loss_mode_q;
  logic [15:0] lr_q;
  logic signed [31:0] weight_q, bias_q, res_q;
  logic signed [47:0] wsum_q, bsum_q, avg_w_q, avg_b_q;
  logic [CntW-1:0] cnt_q;
  rgd_pkg::in_item_t item_q;
  logic signed [63:0] prod_q, pred_q, grad_q;
  logic out_valid_q;

  // shared multiplier: 49-bit signed by 17-bit signed (lr and x both fit)
  logic signed [48:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // sigmoid table, built at elaboration: entry k is sigmoid at its bin midpoint
  logic [16:0] sig_rom [SIGMOID_ENTRIES];
  for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_rom
    localparam longint Mid = -64'sd524288 + longint'(k) * BinW + BinW / 2;
    localparam longint unsigned Decay = rgd_pkg::exp_neg_q32((Mid >= 0) ? Mid : -Mid);
    localparam longint unsigned Den = 64'd4294967296 + Decay;
    localparam logic [16:0] Entry = (Mid >= 0) ? 17'((64'd1 << 48) / Den)
                                               : 17'((Decay << 16) / Den);
    assign sig_rom[k] = Entry;
  end

  logic signed [63:0] yq, pofs, lin_r, sig_s, g;
  logic [SigIdxW-1:0] sidx;
  logic signed [47:0] wsum_nx, bsum_nx;
  logic [CntW-1:0] cnt_nx;
  always_comb begin
    yq = 64'(item_q.target_label) <<< 16;
    pofs = pred_q + 64'sd524288;
    if (pofs < 0) sidx = '0;
    else if ((pofs >>> BinShift) > 64'(SIGMOID_ENTRIES - 1)) sidx = SigIdxW'(SIGMOID_ENTRIES - 1);
    else sidx = SigIdxW'(pofs >>> BinShift);
    sig_s = 64'(sig_rom[sidx]);
    lin_r = 64'(rgd_pkg::sat32(pred_q - yq));
    g = loss_mode_q ? sig_s - yq : lin_r <<< 1;
    // sums and count including this sample
    wsum_nx = rgd_pkg::sat48(64'(wsum_q) + grad_q);
    bsum_nx = rgd_pkg::sat48(64'(bsum_q) + g);
    cnt_nx = (cnt_q < CntW'(MAX_BATCH)) ? cnt_q + CntW'(1) : cnt_q;
  end

  // divider
  logic div_start, div_done;
  logic signed [47:0] div_num, div_quo;
  logic [CntW-1:0] div_den;
  rgd_divider #(.DenW(CntW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_PRED:  begin mul_a = 49'(weight_q); mul_b = 17'(item_q.sample_value); end
      S_GRAD:  begin mul_a = 49'(g); mul_b = 17'(item_q.sample_value); end
      S_STEPW: begin mul_a = 49'(avg_w_q); mul_b = 17'({1'b0, lr_q}); end
      S_STEPB: begin mul_a = 49'(avg_b_q); mul_b = 17'({1'b0, lr_q}); end
      default: ;
    endcase
  end

  // weight division starts with the sum that already holds this sample
  assign div_start = (state_q == S_ACC && item_q.batch_end) || (state_q == S_DIVW && div_done);
  assign div_num = (state_q == S_ACC) ? wsum_nx : bsum_q;
  assign div_den = (state_q == S_ACC) ? cnt_nx : cnt_q;

  assign in_if.ready = (state_q == S_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.data = '{weight_now: weight_q, bias_now: bias_q, residual: res_q,
                         weights_updated: item_q.batch_end};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      loss_mode_q <= 1'b0;
      lr_q <= 16'(rgd_pkg::LrReset);
      weight_q <= '0;
      bias_q <= '0;
      wsum_q <= '0;
      bsum_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rgd_pkg::CfgIdxW'(rgd_pkg::RegLossMode)) loss_mode_q <= cfg_data_i[0];
        else if (cfg_idx_i == rgd_pkg::CfgIdxW'(rgd_pkg::RegLearnRate)) lr_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: if (in_if.valid) state_q <= S_PRED;
        S_PRED: state_q <= S_PADD;
        S_PADD: state_q <= S_GRAD;
        S_GRAD: state_q <= S_ACC;
        S_ACC: begin
          wsum_q <= wsum_nx;
          bsum_q <= bsum_nx;
          cnt_q <= cnt_nx;
          state_q <= S_OUT;
          if (item_q.batch_end) state_q <= S_DIVW;
        end
        S_DIVW: if (div_done) state_q <= S_DIVB;
        S_DIVB: if (div_done) state_q <= S_STEPW;
        S_STEPW: begin
          weight_q <= rgd_pkg::sat32(64'(weight_q) - 64'(mul_p >>> 16));
          state_q <= S_STEPB;
        end
        S_STEPB: begin
          bias_q <= rgd_pkg::sat32(64'(bias_q) - 64'(mul_p >>> 16));
          wsum_q <= '0;
          bsum_q <= '0;
          cnt_q <= '0;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q) out_valid_q <= 1'b1;
          else if (out_if.ready) begin
            out_valid_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_if.valid) item_q <= in_if.data;
    if (state_q == S_PRED) prod_q <= 64'(mul_p >>> 8);
    if (state_q == S_PADD) pred_q <= prod_q + 64'(bias_q);
    if (state_q == S_GRAD) begin
      grad_q <= 64'(mul_p >>> 8);
      res_q <= loss_mode_q ? 32'(yq - sig_s) : lin_r[31:0];
    end
    if (state_q == S_DIVW && div_done) avg_w_q <= div_quo;
    if (state_q == S_DIVB && div_done) avg_b_q <= div_quo;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_if.valid |-> state_q == S_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("accepted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == S_STEPB |=> cnt_q == '0)
    else $error("count not cleared after update");
endmodule

[bench/tb_regression_gradient_descent.sv]
// Testbench: regression_gradient_descent checked against its own predictor.
`timescale 1ns / 1ps
module tb_regression_gradient_descent;

  localparam int unsigned MaxBatch = 1024;
  localparam int unsigned SigEntries = 256;
  localparam int unsigned RandItems = 680;
  localparam int unsigned StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rgd_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [rgd_pkg::CfgDataW-1:0] cfg_data_i = '0;

  rgd_if #(.T(rgd_pkg::in_item_t)) in_if ();
  rgd_if #(.T(rgd_pkg::out_item_t)) out_if ();

  regression_gradient_descent dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if.sink), .out_if(out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state, kept wide; the saturation bounds hold it inside the block's widths.
  logic mode_q;
  logic [15:0] rate_q;
  longint w_q, b_q, wsum_q, bsum_q;
  int unsigned count_q;
  longint sig_lut [SigEntries];

  rgd_pkg::out_item_t expected_q[$];
  int errors = 0;
  int unsigned idle_cycles = 0;

  // Floor division by 2^s is what >>> does on a signed longint.
  function automatic longint clip(longint v, longint hi);
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // e^-a in Q.32 by a cubic series raised to the 256th power.
  function automatic longint unsigned decay_q32(longint unsigned a);
    longint unsigned u, u2, u3, v;
    u = a << 8;
    u2 = (u * u) >> 32;
    u3 = (u2 * u) >> 32;
    v = 64'd4294967296 - u + u2 / 2 - u3 / 6;
    if (v > 64'd4294967295) v = 64'd4294967295;
    repeat (8) v = (v * v) >> 32;
    return v;
  endfunction

  function automatic void fill_sigmoid();
    longint wd, t;
    longint unsigned e;
    wd = 1048576 / SigEntries;
    for (int k = 0; k < SigEntries; k++) begin
      t = -524288 + k * wd + wd / 2;
      if (t >= 0) begin
        e = decay_q32(t);
        sig_lut[k] = longint'((64'd1 << 48) / (64'd4294967296 + e));
      end else begin
        e = decay_q32(-t);
        sig_lut[k] = longint'((e << 16) / (64'd4294967296 + e));
      end
    end
  endfunction

  // One sample through the descent step; returns the result the block should emit.
  function automatic rgd_pkg::out_item_t descend(rgd_pkg::in_item_t s);
    rgd_pkg::out_item_t o;
    longint x, yq, p, r, g, dw, db, idx, sig;
    x = s.sample_value;
    yq = longint'(s.target_label) * 65536;
    p = ((w_q * x) >>> 8) + b_q;
    if (!mode_q) begin
      r = clip(p - yq, 2147483647);
      o.residual = r[31:0];
      dw = (2 * r * x) >>> 8;
      db = 2 * r;
    end else begin
      if (p < -524288) idx = 0;
      else idx = (p + 524288) / (1048576 / SigEntries);
      if (idx > SigEntries - 1) idx = SigEntries - 1;
      sig = sig_lut[idx];
      g = sig - yq;
      r = yq - sig;
      o.residual = r[31:0];
      dw = (g * x) >>> 8;
      db = g;
    end
    wsum_q = clip(wsum_q + dw, 64'sd140737488355327);
    bsum_q = clip(bsum_q + db, 64'sd140737488355327);
    if (count_q < MaxBatch) count_q++;
    if (s.batch_end) begin
      // signed division, truncating toward zero
      w_q = clip(w_q - ((longint'(rate_q) * (wsum_q / longint'(count_q))) >>> 16),
                 2147483647);
      b_q = clip(b_q - ((longint'(rate_q) * (bsum_q / longint'(count_q))) >>> 16),
                 2147483647);
      wsum_q = 0;
      bsum_q = 0;
      count_q = 0;
    end
    o.weight_now = w_q[31:0];
    o.bias_now = b_q[31:0];
    o.weights_updated = s.batch_end;
    return o;
  endfunction

  // Register write at one edge; only called while the block is idle.
  task automatic write_reg(logic [rgd_pkg::CfgIdxW-1:0] idx,
                           logic [rgd_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rgd_pkg::RegLossMode) mode_q = val[0];
    else rate_q = val;
  endtask

  int burst_left = 0;

  // Ends any open burst and waits until every result is out.
  task automatic drain();
    if (burst_left != 0) begin
      in_if.valid <= 1'b0;
      burst_left = 0;
    end
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);  // idle margin before the next register write
  endtask

  // Sender: bursts of random length with random gaps. One transaction per call.
  // valid is already low when a new burst starts.
  task automatic send(rgd_pkg::in_item_t s);
    if (burst_left == 0) begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 12) : 1) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    in_if.valid <= 1'b1;
    in_if.data <= s;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_q.push_back(descend(s));
    burst_left--;
    if (burst_left == 0) in_if.valid <= 1'b0;
  endtask

  // Receiver: stall pattern, switching between free running and random stalls.
  logic stall_phase = 1'b0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_phase <= ~stall_phase;
    out_if.ready <= stall_phase ? ($urandom_range(0, 2) == 0) : 1'b1;
  end

  // Checker and watchdog.
  always @(posedge clk_i) begin
    rgd_pkg::out_item_t exp_r;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("[regression_gradient_descent] ERROR");
        $finish;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transaction");
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_if.data.weight_now !== exp_r.weight_now) begin
            $error("weight_now exp %0d got %0d", exp_r.weight_now, out_if.data.weight_now);
            errors++;
          end
          if (out_if.data.bias_now !== exp_r.bias_now) begin
            $error("bias_now exp %0d got %0d", exp_r.bias_now, out_if.data.bias_now);
            errors++;
          end
          if (out_if.data.residual !== exp_r.residual) begin
            $error("residual exp %0d got %0d", exp_r.residual, out_if.data.residual);
            errors++;
          end
          if (out_if.data.weights_updated !== exp_r.weights_updated) begin
            $error("weights_updated exp %0b got %0b", exp_r.weights_updated,
                   out_if.data.weights_updated);
            errors++;
          end
        end
      end
    end
  end

  // Directed table: value, label, batch end, and a typed-in residual where obvious.
  typedef struct {
    logic signed [15:0] x;
    logic signed [7:0]  y;
    logic               last;
    logic               known;
    logic signed [31:0] res;
  } row_t;

  row_t rows[] = '{
    // fresh reset, weight and bias zero: linear residual is -y
    '{16'sd0,     8'sd0,    1'b0, 1'b1, 32'sd0},
    '{16'sd32767, 8'sd127,  1'b0, 1'b1, -32'sd8323072},
    '{16'sh8000,  8'sh80,   1'b1, 1'b1, 32'sd8388608},
    '{16'sd256,   8'sd1,    1'b0, 1'b0, 32'sd0},
    '{-16'sd256,  -8'sd1,   1'b0, 1'b0, 32'sd0},
    '{16'sd32767, 8'sh80,   1'b0, 1'b0, 32'sd0},
    '{16'sd1,     8'sd3,    1'b1, 1'b0, 32'sd0},
    '{16'sd512,   8'sd2,    1'b1, 1'b0, 32'sd0}
  };

  // Typed-in residuals only hold on the pass straight after reset.
  task automatic run_rows(bit check_known);
    rgd_pkg::in_item_t s;
    foreach (rows[i]) begin
      s = '{rows[i].x, rows[i].y, rows[i].last};
      send(s);
      if (check_known && rows[i].known && expected_q[$].residual !== rows[i].res) begin
        $error("residual table exp %0d predicted %0d", rows[i].res, expected_q[$].residual);
        errors++;
      end
    end
    drain();
  endtask

  // Random batch with random content; labels mostly 0/1 in logistic mode.
  task automatic random_batch(int unsigned n, int unsigned xspan);
    rgd_pkg::in_item_t s;
    for (int unsigned i = 0; i < n; i++) begin
      s.sample_value = (xspan == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 2 * xspan)) - xspan);
      if (mode_q && $urandom_range(0, 9) != 0) s.target_label = 8'($urandom_range(0, 1));
      else s.target_label = 8'($urandom);
      s.batch_end = (i == n - 1);
      send(s);
    end
  endtask

  initial begin
    int unsigned sent;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    mode_q = 1'b0;
    rate_q = 16'(rgd_pkg::LrReset);
    w_q = 0; b_q = 0; wsum_q = 0; bsum_q = 0; count_q = 0;
    fill_sigmoid();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_rows(1'b1);
    write_reg(rgd_pkg::RegLossMode, 16'd1);
    run_rows(1'b0);  // logistic at the same extremes, warm start
    write_reg(rgd_pkg::RegLearnRate, 16'hffff);
    run_rows(1'b0);
    write_reg(rgd_pkg::RegLearnRate, 16'd0);
    write_reg(rgd_pkg::RegLossMode, 16'd0);
    run_rows(1'b0);

    sent = 0;
    while (sent < RandItems) begin
      case ($urandom_range(0, 5))
        0: write_reg(rgd_pkg::RegLossMode, 16'($urandom_range(0, 1)));
        1: write_reg(rgd_pkg::RegLearnRate, 16'($urandom));
        2: write_reg(rgd_pkg::RegLearnRate, 16'($urandom_range(0, 4000)));
        default: ;
      endcase
      for (int k = 0; k < 6; k++) begin
        int unsigned n;
        n = ($urandom_range(0, 30) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
        random_batch(n, ($urandom_range(0, 3) == 0) ? 0 : 1024);
        sent += n;
      end
      drain();
    end
    // long batch to push the count past its saturation point
    write_reg(rgd_pkg::RegLearnRate, 16'd16);
    random_batch(MaxBatch + 20, 256);
    drain();

    if (errors == 0) $display("[regression_gradient_descent] OK");
    else $display("[regression_gradient_descent] ERROR");
    $finish;
  end
endmodule

[files.f]
hdl/rgd_pkg.sv
hdl/rgd_if.sv
hdl/rgd_divider.sv
hdl/regression_gradient_descent.sv
bench/tb_regression_gradient_descent.sv
